>>> hdl/mgm_pkg.sv
// ============================================================================
// mgm_pkg
// Shared types, constants and field arithmetic for the masked GF(2^8)
// multiplier.
// ============================================================================
package mgm_pkg;

    localparam int BYTE_W      = 8;
    localparam int SHARE_MAX   = 4;
    localparam int SHARES_W    = SHARE_MAX * BYTE_W;
    localparam int RAND_W      = 48;
    localparam int CLMUL_W     = 2 * BYTE_W - 1;
    localparam logic [BYTE_W:0] GF_POLY = 9'h11B;

    // Load enables of the two register stages inside one field multiplier.
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    // Carry-less product of two bytes.
    function automatic logic [CLMUL_W-1:0] clmul(input logic [BYTE_W-1:0] x,
                                                 input logic [BYTE_W-1:0] y);
        logic [CLMUL_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (y[k]) begin
                acc = acc ^ (CLMUL_W'(x) << k);
            end
        end
        return acc;
    endfunction

    // Reduction of a carry-less product modulo the AES polynomial.
    function automatic logic [BYTE_W-1:0] gf_reduce(input logic [CLMUL_W-1:0] v);
        logic [CLMUL_W-1:0] acc;
        acc = v;
        for (int k = CLMUL_W - 1; k >= BYTE_W; k--) begin
            if (acc[k]) begin
                acc = acc ^ (CLMUL_W'(GF_POLY) << (k - BYTE_W));
            end
        end
        return acc[BYTE_W-1:0];
    endfunction

    // Position of pair (i, j), i < j, in the row-major upper triangle of an
    // n by n matrix.
    function automatic int pair_index(input int i, input int j, input int n);
        int idx;
        idx = 0;
        for (int row = 0; row < i; row++) begin
            idx = idx + (n - 1 - row);
        end
        return idx + (j - i - 1);
    endfunction

endpackage

>>> hdl/mgm_if.sv
// ============================================================================
// mgm_in_if / mgm_out_if
// Valid/ready channels for the operand and product transfers.
// ============================================================================
interface mgm_in_if;
    import mgm_pkg::*;

    logic                valid;
    logic                ready;
    logic [SHARES_W-1:0] a_shares;
    logic [SHARES_W-1:0] b_shares;
    logic [RAND_W-1:0]   rand_bytes;

    modport source (output valid, output a_shares, output b_shares,
                    output rand_bytes, input ready);
    modport sink   (input valid, input a_shares, input b_shares,
                    input rand_bytes, output ready);
endinterface

interface mgm_out_if;
    import mgm_pkg::*;

    logic                valid;
    logic                ready;
    logic [SHARES_W-1:0] c_shares;

    modport source (output valid, output c_shares, input ready);
    modport sink   (input valid, input c_shares, output ready);
endinterface

>>> hdl/mgm_gf_mult.sv
// ============================================================================
// mgm_gf_mult
// Two-stage GF(2^8) multiplier: carry-less product, then polynomial
// reduction.
// ============================================================================
module mgm_gf_mult (
    input  logic                    clk,
    input  mgm_pkg::stage_en_t      en,
    input  logic [7:0]              x,
    input  logic [7:0]              y,
    output logic [7:0]              p
);
    import mgm_pkg::*;

    logic [CLMUL_W-1:0] prod_reg;
    logic [BYTE_W-1:0]  red_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= clmul(x, y);
        end
        if (en.s2)
        begin
            red_reg <= gf_reduce(prod_reg);
        end
    end

    assign p = red_reg;

endmodule

>>> hdl/masked_gf256_multiplier.sv
// ============================================================================
// masked_gf256_multiplier
// ISW masked multiplication of two Boolean-shared bytes in GF(2^8).
// ============================================================================
// The block takes all shares of a, all shares of b and the fresh random bytes
// of one multiplication in a single transfer and returns all shares of the
// product in a single transfer. MASKING_ORDER (1 to 3) sets the share count
// to MASKING_ORDER+1; share bytes above that count are ignored on input and
// driven as zero on output, and only the first MASKING_ORDER*(MASKING_ORDER+1)/2
// random bytes are used, filling the upper triangle row by row. Throughput is
// one item per clock cycle unless the output stalls; an accepted item reaches
// output valid through the three register stages: carry-less partial products
// of every share pair, their reduction modulo 0x11B, and the ISW combination
// of reduced products with the random bytes into the output register. Each
// stage moves when it is empty or when the stage after it moves, so bubbles
// are squeezed out and a stalled consumer holds the pipeline without loss.
// ============================================================================
module masked_gf256_multiplier #(
    parameter int MASKING_ORDER = 3
) (
    input  logic      clk,
    input  logic      rst_n,
    mgm_in_if.sink    operands,
    mgm_out_if.source product
);
    import mgm_pkg::*;

    localparam int SHARES = (MASKING_ORDER < 1) ? 2 :
                            ((MASKING_ORDER > 3) ? SHARE_MAX : MASKING_ORDER + 1);

    // Stage valid bits and stage advance conditions.
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // Random bytes ride alongside the products through the first two stages.
    logic [RAND_W-1:0]   rand1_reg, rand2_reg;
    logic [SHARES_W-1:0] c_shares_reg, c_shares_next;

    stage_en_t en;

    // Reduced products a_i*b_j, valid at the end of stage two.
    logic [BYTE_W-1:0] prod [SHARES][SHARES];

    assign adv3 = !v3_reg || product.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign en.s1 = adv1;
    assign en.s2 = adv2;

    assign operands.ready   = adv1;
    assign product.valid    = v3_reg;
    assign product.c_shares = c_shares_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= operands.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            rand1_reg <= operands.rand_bytes;
        end
        if (adv2)
        begin
            rand2_reg <= rand1_reg;
        end
        if (adv3)
        begin
            c_shares_reg <= c_shares_next;
        end
    end

    // One field multiplier for every ordered share pair.
    for (genvar gi = 0; gi < SHARES; gi++) begin : g_row
        for (genvar gj = 0; gj < SHARES; gj++) begin : g_col
            mgm_gf_mult u_mult (
                .clk (clk),
                .en  (en),
                .x   (operands.a_shares[gi*BYTE_W +: BYTE_W]),
                .y   (operands.b_shares[gj*BYTE_W +: BYTE_W]),
                .p   (prod[gi][gj])
            );
        end
    end

    // ISW combination. For i < j the upper term is the random byte r_ij and
    // the mirrored term is r_ji = (r_ij ^ a_i*b_j) ^ a_j*b_i. Share c_i is
    // its own product XOR every r_ij with j != i.
    always_comb
    begin
        logic [BYTE_W-1:0] r_mat [SHARES][SHARES];
        logic [BYTE_W-1:0] acc;
        for (int i = 0; i < SHARES; i++) begin
            for (int j = 0; j < SHARES; j++) begin
                r_mat[i][j] = '0;
            end
        end
        for (int i = 0; i < SHARES; i++) begin
            for (int j = i + 1; j < SHARES; j++) begin
                r_mat[i][j] = rand2_reg[pair_index(i, j, SHARES)*BYTE_W +: BYTE_W];
                r_mat[j][i] = (r_mat[i][j] ^ prod[i][j]) ^ prod[j][i];
            end
        end
        c_shares_next = '0;
        for (int i = 0; i < SHARES; i++) begin
            acc = prod[i][i];
            for (int j = 0; j < SHARES; j++) begin
                if (j != i) begin
                    acc = acc ^ r_mat[i][j];
                end
            end
            c_shares_next[i*BYTE_W +: BYTE_W] = acc;
        end
    end

    // A transfer on the input always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        operands.valid && operands.ready |=> v1_reg)
        else $error("accepted operands did not enter the first stage");

    // Back pressure reaches the input only when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !operands.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled while the pipeline has a free stage");

    // An occupied middle stage is never dropped while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !adv3 |=> v2_reg && v3_reg)
        else $error("middle stage lost its item during a stall");

endmodule

>>> sim/masked_gf256_multiplier_tb.sv
// ============================================================================
// masked_gf256_multiplier_tb
// Self-checking testbench for the ISW masked GF(2^8) multiplier.
// ============================================================================
// Operand transfers are driven on the input channel. Every accepted transfer
// is run through a behavioral ISW product computed here, and the resulting
// shares are queued. Each product transfer is compared with the oldest queued
// value. The run walks through directed corner cases, random phases with
// different amounts of sender idling and receiver stalling, and a long
// receiver hold-off that fills the pipeline and stalls the input.
// ============================================================================
module masked_gf256_multiplier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgm_pkg::*;

    localparam int MASKING_ORDER  = 3;
    // The share count is clamped so that all shares fit the 32-bit fields.
    localparam int SHARE_COUNT    = (MASKING_ORDER < 1) ? 2 :
                                    (MASKING_ORDER > 3) ? SHARE_MAX : MASKING_ORDER + 1;
    localparam int PIPE_LATENCY   = 3;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    logic clk = 1'b0;
    logic rst_n;

    mgm_in_if  operands();
    mgm_out_if product();

    masked_gf256_multiplier #(
        .MASKING_ORDER(MASKING_ORDER)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .product  (product)
    );

    // Product shares still owed by the block, oldest first.
    logic [SHARES_W-1:0] pending_products[$];

    int mismatches   = 0;
    int cycle_count  = 0;
    // Percent chance per cycle that the sender idles or the receiver stalls.
    int idle_pct     = 0;
    int stall_pct    = 0;
    // A hold-off is requested by bumping this count; the ready process sees
    // the change and then holds ready low on its own until its count runs out.
    int holdoff_reqs = 0;
    int holdoff_seen;
    int holdoff_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral field arithmetic and ISW combination.
    // ------------------------------------------------------------------------

    // Shift-and-add product in GF(2^8), reducing by x^8+x^4+x^3+x+1 at each
    // doubling. Either operand being zero naturally yields zero.
    function automatic logic [BYTE_W-1:0] gf_mult(input logic [BYTE_W-1:0] x,
                                                  input logic [BYTE_W-1:0] y);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] run;
        acc = '0;
        run = x;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (y[k])
            begin
                acc = acc ^ run;
            end
            run = {run[BYTE_W-2:0], 1'b0} ^ (run[BYTE_W-1] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    // Output shares of the masked product. The random bytes fill the upper
    // triangle row by row; each mirrored entry is built as the random byte
    // plus the two cross products, in that order. Share bytes above the
    // share count stay zero.
    function automatic logic [SHARES_W-1:0] isw_product(input logic [SHARES_W-1:0] a,
                                                        input logic [SHARES_W-1:0] b,
                                                        input logic [RAND_W-1:0]   r);
        logic [BYTE_W-1:0]   mix[SHARE_MAX][SHARE_MAX];
        logic [BYTE_W-1:0]   ai;
        logic [BYTE_W-1:0]   aj;
        logic [BYTE_W-1:0]   bi;
        logic [BYTE_W-1:0]   bj;
        logic [BYTE_W-1:0]   share;
        logic [SHARES_W-1:0] shares;
        int                  rpos;
        rpos   = 0;
        shares = '0;
        for (int i = 0; i < SHARE_MAX; i++)
        begin
            for (int j = 0; j < SHARE_MAX; j++)
            begin
                mix[i][j] = '0;
            end
        end
        for (int i = 0; i < SHARE_COUNT; i++)
        begin
            for (int j = i + 1; j < SHARE_COUNT; j++)
            begin
                ai = a[i*BYTE_W +: BYTE_W];
                aj = a[j*BYTE_W +: BYTE_W];
                bi = b[i*BYTE_W +: BYTE_W];
                bj = b[j*BYTE_W +: BYTE_W];
                mix[i][j] = r[rpos*BYTE_W +: BYTE_W];
                mix[j][i] = (mix[i][j] ^ gf_mult(ai, bj)) ^ gf_mult(aj, bi);
                rpos++;
            end
        end
        for (int i = 0; i < SHARE_COUNT; i++)
        begin
            share = gf_mult(a[i*BYTE_W +: BYTE_W], b[i*BYTE_W +: BYTE_W]);
            for (int j = 0; j < SHARE_COUNT; j++)
            begin
                if (j != i)
                begin
                    share = share ^ mix[i][j];
                end
            end
            shares[i*BYTE_W +: BYTE_W] = share;
        end
        return shares;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: ready generation with random stalls and the long
    // hold-off. Ready is driven only by nonblocking assignments at the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product.ready <= 1'b0;
            holdoff_seen  <= 0;
            holdoff_left  <= 0;
        end
        else if (holdoff_seen != holdoff_reqs)
        begin
            holdoff_seen  <= holdoff_reqs;
            holdoff_left  <= HOLDOFF_CYCLES;
            product.ready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left  <= holdoff_left - 1;
            product.ready <= 1'b0;
        end
        else
        begin
            product.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Transfer monitor and checker. Input transfers are predicted before the
    // output side is looked at, so a product can never be checked against an
    // expectation that is queued later in the same cycle.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what,
                                   input logic [SHARES_W-1:0] want,
                                   input logic [SHARES_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("[%0t] %s: c_shares expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_transfers
        logic [SHARES_W-1:0] want;
        if (rst_n)
        begin
            if (operands.valid && operands.ready)
            begin
                pending_products.push_back(isw_product(operands.a_shares,
                                                       operands.b_shares,
                                                       operands.rand_bytes));
            end
            if (product.valid && product.ready)
            begin
                if (pending_products.size() == 0)
                begin
                    report_mismatch("unexpected product transfer", 'x, product.c_shares);
                end
                else
                begin
                    want = pending_products.pop_front();
                    if (product.c_shares !== want)
                    begin
                        report_mismatch("product mismatch", want, product.c_shares);
                    end
                end
            end
        end
    end

    // A run that stalls for good, including one with products never
    // delivered, ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one operand transfer and returns in the time step of the edge
    // where it was accepted. Valid stays high into the next call unless that
    // call starts with an idle cycle.
    task automatic send_operands(input logic [SHARES_W-1:0] a,
                                 input logic [SHARES_W-1:0] b,
                                 input logic [RAND_W-1:0]   r);
        while ($urandom_range(99) < idle_pct)
        begin
            operands.valid <= 1'b0;
            @(posedge clk);
        end
        operands.valid      <= 1'b1;
        operands.a_shares   <= a;
        operands.b_shares   <= b;
        operands.rand_bytes <= r;
        @(posedge clk);
        while (!operands.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drops valid and waits until every owed product has arrived, then lets
    // the pipeline settle so that a stray extra product would be seen.
    task automatic drain;
        operands.valid <= 1'b0;
        @(posedge clk);
        while (pending_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 5) @(posedge clk);
    endtask

    // Mostly uniform bytes, with zero, one and all-ones mixed in so that the
    // zero-operand case and the reduction path show up often.
    function automatic logic [BYTE_W-1:0] pick_byte;
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SHARES_W-1:0] pick_shares;
        logic [SHARES_W-1:0] v;
        if ($urandom_range(3) == 0)
        begin
            v = $urandom;
        end
        else
        begin
            for (int i = 0; i < SHARE_MAX; i++)
            begin
                v[i*BYTE_W +: BYTE_W] = pick_byte();
            end
        end
        return v;
    endfunction

    function automatic logic [RAND_W-1:0] pick_random_bytes;
        return RAND_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Field extremes, zero operands, reduction-heavy products, and patterns
    // that exercise every share position and random-byte position alone.
    task automatic test_directed;
        idle_pct  = 0;
        stall_pct = 0;
        send_operands('0, '0, '0);
        send_operands('1, '1, '1);
        send_operands('0, 32'hDEADBEEF, 48'h0123456789AB);
        send_operands(32'hCAFEF00D, '0, 48'hFEDCBA987654);
        send_operands(32'h01010101, 32'h01010101, '0);
        send_operands(32'h80808080, 32'h80808080, '0);
        send_operands(32'h00000053, 32'h000000CA, '0);
        send_operands(32'h000000FF, 32'h0000FF00, 48'hFFFFFFFFFFFF);
        send_operands(32'hFF000000, 32'h00FF0000, 48'h000000000000);
        send_operands(32'h00FF0000, 32'hFF000000, 48'h00000000FF00);
        for (int i = 0; i < SHARE_MAX; i++)
        begin
            send_operands(32'h57 << (i * BYTE_W), 32'h83 << (i * BYTE_W), '0);
        end
        for (int k = 0; k < RAND_W / BYTE_W; k++)
        begin
            send_operands(32'h11223344, 32'h55667788, 48'hA5 << (k * BYTE_W));
        end
        send_operands(32'hAAAAAAAA, 32'h55555555, 48'h5A5A5A5A5A5A);
        drain();
    endtask

    // One random phase with the given sender idle and receiver stall rates.
    task automatic test_random(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
        begin
            send_operands(pick_shares(), pick_shares(), pick_random_bytes());
        end
        drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering transfers back to back, so the pipeline fills and the input
    // stalls, then everything must drain in order once ready returns.
    task automatic test_backpressure;
        idle_pct  = 0;
        stall_pct = 0;
        holdoff_reqs++;
        for (int n = 0; n < 60; n++)
        begin
            send_operands(pick_shares(), pick_shares(), pick_random_bytes());
        end
        drain();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        product.ready       = 1'b0;
        operands.valid      = 1'b0;
        operands.a_shares   = '0;
        operands.b_shares   = '0;
        operands.rand_bytes = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400, 0, 0);
        test_random(400, 65, 0);
        test_random(400, 0, 65);
        test_random(400, 11, 11);
        test_backpressure();

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/mgm_pkg.sv
hdl/mgm_if.sv
hdl/mgm_gf_mult.sv
hdl/masked_gf256_multiplier.sv
sim/masked_gf256_multiplier_tb.sv
